// ===== hdl/bub_pkg.sv =====
`default_nettype none

package bub_pkg;

	// Field and storage widths fixed by the block's definition
	localparam int RANK_W  = 53;
	localparam int PAIR_W  = 5;
	localparam int BR_W    = 2;
	localparam int ENTRY_W = 38;

	// Bracket codes, ordered as the ranking orders them
	typedef enum logic [BR_W-1:0] {
		BR_OPEN_ROUND   = 2'd0,
		BR_CLOSE_ROUND  = 2'd1,
		BR_OPEN_SQUARE  = 2'd2,
		BR_CLOSE_SQUARE = 2'd3
	} bracket_t;

	// Sequencer of the top level
	typedef enum logic [2:0] {
		ST_WAIT_TABLE,
		ST_IDLE,
		ST_READ,
		ST_SCALE,
		ST_DECIDE
	} state_t;

	// Table fill sweep
	typedef enum logic {
		FILL_SWEEP,
		FILL_DONE
	} fill_state_t;

endpackage

`default_nettype wire

// ===== hdl/bub_ifs.sv =====
`default_nettype none

// Rank request channel
interface bub_rank_if;
	logic                        valid;
	logic                        ready;
	logic [bub_pkg::RANK_W-1:0]  rank;

	modport source (output valid, output rank, input ready);
	modport sink (input valid, input rank, output ready);
endinterface

// Bracket result channel
interface bub_bracket_if;
	logic                      valid;
	logic                      ready;
	logic [bub_pkg::BR_W-1:0]  bracket;
	logic                      last;
	logic                      rank_error;

	modport source (output valid, output bracket, output last, output rank_error, input ready);
	modport sink (input valid, input bracket, input last, input rank_error, output ready);
endinterface

`default_nettype wire

// ===== hdl/bub_table.sv =====
`default_nettype none

// Walk count table: one synchronous memory, filled row by row after reset
// from the ballot recurrence, then read through two ports.
module bub_table #(
	parameter int MAX_PAIRS = 20
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	output logic                                              ready,
	input  wire logic [$clog2((2*MAX_PAIRS+1)**2)-1:0]        addr_a,
	input  wire logic [$clog2((2*MAX_PAIRS+1)**2)-1:0]        addr_b,
	output logic [bub_pkg::ENTRY_W-1:0]                       data_a,
	output logic [bub_pkg::ENTRY_W-1:0]                       data_b
);

	localparam int DIM = 2*MAX_PAIRS + 1;
	localparam int AW  = $clog2(DIM*DIM);
	localparam int XW  = $clog2(DIM);
	localparam int KW  = $clog2(DIM+1);

	logic [bub_pkg::ENTRY_W-1:0] mem [DIM*DIM];
	logic [bub_pkg::ENTRY_W-1:0] rd_a_q;
	logic [bub_pkg::ENTRY_W-1:0] rd_b_q;

	bub_pkg::fill_state_t fill_state_q, fill_state_d;
	logic [XW-1:0] fi_q;
	logic [KW-1:0] fk_q;
	logic          sweep;
	logic          row_end;
	logic          fv_s1;
	logic [XW-1:0] fi_s1;
	logic [KW-1:0] fk_s1;
	logic [bub_pkg::ENTRY_W-1:0] wa_q;
	logic [bub_pkg::ENTRY_W-1:0] wb_q;
	logic [bub_pkg::ENTRY_W-1:0] rin;
	logic [AW-1:0] fill_raddr;
	logic [AW-1:0] raddr_a;
	logic          we;
	logic [AW-1:0] waddr;
	logic [bub_pkg::ENTRY_W-1:0] wdata;

	assign row_end = (fk_q == KW'(DIM));

	// Next state of the fill sweep
	always_comb begin
		fill_state_d = fill_state_q;
		case (fill_state_q)
			bub_pkg::FILL_SWEEP: begin
				if (row_end && fi_q == XW'(DIM-1)) fill_state_d = bub_pkg::FILL_DONE;
			end
			bub_pkg::FILL_DONE: fill_state_d = bub_pkg::FILL_DONE;
			default: fill_state_d = bub_pkg::FILL_SWEEP;
		endcase
	end

	// Outputs of the fill sweep
	always_comb begin
		sweep = 1'b0;
		ready = 1'b0;
		case (fill_state_q)
			bub_pkg::FILL_SWEEP: sweep = 1'b1;
			bub_pkg::FILL_DONE:  ready = !fv_s1;
			default: ;
		endcase
	end

	// Advance row and column counters; one column issued per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_state_q <= bub_pkg::FILL_SWEEP;
			fi_q         <= '0;
			fk_q         <= '0;
			fv_s1        <= 1'b0;
		end else begin
			fill_state_q <= fill_state_d;
			fv_s1        <= sweep;
			if (sweep) begin
				if (row_end) begin
					fk_q <= '0;
					fi_q <= fi_q + XW'(1);
				end else begin
					fk_q <= fk_q + KW'(1);
				end
			end
		end
	end

	// Previous row, column k, read while row i is built
	assign fill_raddr = (fi_q == '0) ? '0
		: AW'(AW'(fi_q - XW'(1)) * AW'(DIM) + AW'(fk_q));
	assign raddr_a = sweep ? fill_raddr : addr_a;

	// Entry (i, k-1) is the sum of previous-row columns k-2 and k
	assign rin   = (fk_s1 == KW'(DIM)) ? '0 : rd_a_q;
	assign we    = fv_s1 && (fk_s1 != '0);
	assign waddr = AW'(AW'(fi_s1) * AW'(DIM) + AW'(fk_s1) - AW'(1));
	always_comb begin
		if (fi_s1 == '0) begin
			wdata = (fk_s1 == KW'(1)) ? bub_pkg::ENTRY_W'(1) : '0;
		end else begin
			wdata = wb_q + rin;
		end
	end

	// Hold the two-column window of the previous row
	always_ff @(posedge clk) begin
		fi_s1 <= fi_q;
		fk_s1 <= fk_q;
		if (fv_s1) begin
			if (fk_s1 == '0) begin
				wb_q <= '0;
			end else begin
				wb_q <= wa_q;
			end
			wa_q <= rin;
		end
	end

	// Table memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[addr_b];
	end

	assign data_a = rd_a_q;
	assign data_b = rd_b_q;

endmodule

`default_nettype wire

// ===== hdl/two_type_bracket_unranker.sv =====
// Two-type bracket unranker. A rank on the ranks channel yields the balanced
// sequence of pair_count pairs of round and square brackets with that
// zero-based rank in the order ( < ) < [ < ], one bracket per transaction on
// the brackets channel, last set on the final one. A rank at or above the
// number of such sequences yields a single transaction with rank_error and
// last set and bracket '('. pair_count 0 acts as 1, above MAX_PAIRS as
// MAX_PAIRS. After reset the walk count memory is built, and ranks.ready
// stays low until then. A rank first passes once through a memory read, a
// step that scales the counts and forms thresholds, and a compare, to check
// its range; then each position of the sequence passes through the same
// three steps. A stall on the brackets channel holds the compare step.
// The next rank is taken while the last bracket still waits in the output
// register.
`default_nettype none

module two_type_bracket_unranker #(
	parameter int MAX_PAIRS = 20
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [bub_pkg::PAIR_W-1:0]   cfg_wr_data,
	bub_rank_if.sink                          ranks,
	bub_bracket_if.source                     brackets
);

	localparam int DIM   = 2*MAX_PAIRS + 1;
	localparam int XW    = $clog2(DIM);
	localparam int DW    = $clog2(MAX_PAIRS+1);
	localparam int SW    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int AW    = $clog2(DIM*DIM);
	localparam int CNT_W = bub_pkg::ENTRY_W + MAX_PAIRS;
	localparam int THR_W = CNT_W + 2;
	localparam int CMP_W = ((THR_W > bub_pkg::RANK_W) ? THR_W : bub_pkg::RANK_W) + 1;

	bub_pkg::state_t state_q, state_d;

	logic [bub_pkg::PAIR_W-1:0] pair_count_q;
	logic [DW-1:0]              pairs;
	logic [XW-1:0]              len;

	logic [bub_pkg::RANK_W-1:0] rank_q;
	logic [XW-1:0]              x_q;
	logic [DW-1:0]              depth_q;
	logic [MAX_PAIRS-1:0]       types_q;
	logic                       chk_q;
	logic [THR_W-1:0]           t1_q, t2_q, t3_q;

	logic                       out_valid_q;
	bub_pkg::bracket_t          out_bracket_q;
	logic                       out_last_q;
	logic                       out_err_q;

	logic                       tbl_ready;
	logic [AW-1:0]              addr_a, addr_b;
	logic [bub_pkg::ENTRY_W-1:0] data_a, data_b;

	logic                       room;
	logic                       top_round;
	logic [XW-1:0]              d_a, d_b;
	logic [XW-1:0]              sh_a, sh_b;
	logic [CNT_W-1:0]           c1, c2;
	logic [CMP_W-1:0]           diff1, diff2, diff3;
	logic                       lt1, lt2, lt3;
	bub_pkg::bracket_t          br;
	logic [bub_pkg::RANK_W-1:0] rank_next;
	logic                       slot_free;

	logic                       ranks_ready;
	logic                       do_accept, do_pass, do_emit, do_error;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_count_q <= bub_pkg::PAIR_W'(1);
		end else if (cfg_wr_en) begin
			pair_count_q <= cfg_wr_data;
		end
	end

	// Clamp pair count into the supported range
	always_comb begin
		if (pair_count_q == '0) begin
			pairs = DW'(1);
		end else if (pair_count_q > bub_pkg::PAIR_W'(MAX_PAIRS)) begin
			pairs = DW'(MAX_PAIRS);
		end else begin
			pairs = DW'(pair_count_q);
		end
	end
	assign len = XW'({pairs, 1'b0});

	bub_table #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ready  (tbl_ready),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.data_a (data_a),
		.data_b (data_b)
	);

	// Stack top and depth headroom
	assign room      = depth_q < DW'(MAX_PAIRS);
	assign top_round = (depth_q != '0) && !types_q[SW'(depth_q - DW'(1))];

	// Table addresses: one level deeper, and one level shallower; depth zero in the range check
	assign d_a    = chk_q ? '0 : XW'(depth_q) + XW'(1);
	assign d_b    = XW'(depth_q) - ((depth_q != '0) ? XW'(1) : XW'(0));
	assign addr_a = AW'(AW'(x_q) * AW'(DIM) + AW'(d_a));
	assign addr_b = AW'(AW'(x_q) * AW'(DIM) + AW'(d_b));

	// Scale entries by the free type choices of later pairs
	assign sh_a = XW'(x_q - d_a) >> 1;
	assign sh_b = XW'(x_q - d_b) >> 1;
	assign c1   = (chk_q || room) ? (CNT_W'(data_a) << sh_a) : '0;
	assign c2   = (!chk_q && top_round) ? (CNT_W'(data_b) << sh_b) : '0;

	// Cumulative thresholds of the four choices
	always_ff @(posedge clk) begin
		if (state_q == bub_pkg::ST_SCALE) begin
			t1_q <= THR_W'(c1);
			t2_q <= THR_W'(c1) + THR_W'(c2);
			t3_q <= (THR_W'(c1) << 1) + THR_W'(c2);
		end
	end

	// Compare rank against all thresholds at once; borrow marks less-than
	assign diff1 = CMP_W'(rank_q) - CMP_W'(t1_q);
	assign diff2 = CMP_W'(rank_q) - CMP_W'(t2_q);
	assign diff3 = CMP_W'(rank_q) - CMP_W'(t3_q);
	assign lt1   = diff1[CMP_W-1];
	assign lt2   = diff2[CMP_W-1];
	assign lt3   = diff3[CMP_W-1];

	// Select bracket and remaining rank
	always_comb begin
		if (lt1) begin
			br        = bub_pkg::BR_OPEN_ROUND;
			rank_next = rank_q;
		end else if (lt2) begin
			br        = bub_pkg::BR_CLOSE_ROUND;
			rank_next = bub_pkg::RANK_W'(diff1);
		end else if (lt3) begin
			br        = bub_pkg::BR_OPEN_SQUARE;
			rank_next = bub_pkg::RANK_W'(diff2);
		end else begin
			br        = bub_pkg::BR_CLOSE_SQUARE;
			rank_next = bub_pkg::RANK_W'(diff3);
		end
	end

	assign slot_free = !out_valid_q || brackets.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bub_pkg::ST_WAIT_TABLE: begin
				if (tbl_ready) state_d = bub_pkg::ST_IDLE;
			end
			bub_pkg::ST_IDLE: begin
				if (ranks.valid) state_d = bub_pkg::ST_READ;
			end
			bub_pkg::ST_READ:  state_d = bub_pkg::ST_SCALE;
			bub_pkg::ST_SCALE: state_d = bub_pkg::ST_DECIDE;
			bub_pkg::ST_DECIDE: begin
				if (chk_q) begin
					if (lt1) begin
						state_d = bub_pkg::ST_READ;
					end else if (slot_free) begin
						state_d = bub_pkg::ST_IDLE;
					end
				end else if (slot_free) begin
					state_d = (x_q == '0) ? bub_pkg::ST_IDLE : bub_pkg::ST_READ;
				end
			end
			default: state_d = bub_pkg::ST_WAIT_TABLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		ranks_ready = 1'b0;
		do_accept   = 1'b0;
		do_pass     = 1'b0;
		do_emit     = 1'b0;
		do_error    = 1'b0;
		case (state_q)
			bub_pkg::ST_IDLE: begin
				ranks_ready = 1'b1;
				do_accept   = ranks.valid;
			end
			bub_pkg::ST_DECIDE: begin
				if (chk_q) begin
					do_pass  = lt1;
					do_error = !lt1 && slot_free;
				end else begin
					do_emit = slot_free;
				end
			end
			default: ;
		endcase
	end

	assign ranks.ready = ranks_ready;

	// Sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bub_pkg::ST_WAIT_TABLE;
			x_q     <= '0;
			depth_q <= '0;
			types_q <= '0;
			chk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_accept) begin
				x_q     <= len;
				depth_q <= '0;
				types_q <= '0;
				chk_q   <= 1'b1;
			end else if (do_pass) begin
				x_q   <= len - XW'(1);
				chk_q <= 1'b0;
			end else if (do_emit) begin
				x_q <= x_q - XW'(1);
				if (br == bub_pkg::BR_OPEN_ROUND || br == bub_pkg::BR_OPEN_SQUARE) begin
					if (room) begin
						types_q[SW'(depth_q)] <= (br == bub_pkg::BR_OPEN_SQUARE);
						depth_q <= depth_q + DW'(1);
					end
				end else if (depth_q != '0) begin
					depth_q <= depth_q - DW'(1);
				end
			end
		end
	end

	// Remaining rank
	always_ff @(posedge clk) begin
		if (do_accept) begin
			rank_q <= ranks.rank;
		end else if (do_emit) begin
			rank_q <= rank_next;
		end
	end

	// Output register: load a transaction, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit || do_error) begin
			out_valid_q <= 1'b1;
		end else if (brackets.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_error) begin
			out_bracket_q <= bub_pkg::BR_OPEN_ROUND;
			out_last_q    <= 1'b1;
			out_err_q     <= 1'b1;
		end else if (do_emit) begin
			out_bracket_q <= br;
			out_last_q    <= (x_q == '0);
			out_err_q     <= 1'b0;
		end
	end

	assign brackets.valid      = out_valid_q;
	assign brackets.bracket    = out_bracket_q;
	assign brackets.last       = out_last_q;
	assign brackets.rank_error = out_err_q;

endmodule

`default_nettype wire

// ===== hdl/bub_checker.sv =====
`default_nettype none

module bub_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [bub_pkg::BR_W-1:0]   out_bracket,
	input wire logic                       out_last,
	input wire logic                       out_error
);

	// Hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// An error result ends its run and carries an open round bracket
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last && out_bracket == bub_pkg::BR_OPEN_ROUND)
		else $error("error result without last or with wrong bracket");

	// Take no second rank right after one is accepted
	a_one_rank: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("rank accepted while a run is in progress");

	// While ready for a rank, any pending result is the end of a run
	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_last)
		else $error("ready for a rank in the middle of a run");

endmodule

bind two_type_bracket_unranker bub_checker u_bub_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (ranks.valid),
	.in_ready    (ranks.ready),
	.out_valid   (brackets.valid),
	.out_ready   (brackets.ready),
	.out_bracket (brackets.bracket),
	.out_last    (brackets.last),
	.out_error   (brackets.rank_error)
);

`default_nettype wire
